>>> rtl/bgtm_pkg.sv
`default_nettype none
package bgtm_pkg;

  // opcodes of an input item, also the kind of a queued item
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_PIX  = 2'd1;
  localparam logic [1:0] OP_PAL  = 2'd2;

  localparam int POS_W     = 10;
  localparam int TILE_FW   = 10;  // wide enough for the largest tile count
  localparam int PAL_FW    = 4;   // wide enough for the largest palette count
  localparam int COL_W     = 6;
  localparam int ROW_W     = 10;
  localparam int ADDR_W    = 15;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 8;
  localparam int X_W       = 9;
  localparam int Y_W       = 13;
  localparam int WIDTH_W   = 7;
  localparam int MAX_ROW_W = 64;
  localparam int ALPHA_LSB = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = POS_W;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TILE_FW-1:0] tile;
    logic               hflip;
    logic               vflip;
    logic [PAL_FW-1:0]  pal;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ADDR_W-1:0]  addr;
    logic [VAL_W-1:0]   value;
  } bgtm_item_t;

endpackage
`default_nettype wire

>>> rtl/bgtm_ram.sv
`default_nettype none
module bgtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write at the same edge return the old data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bgtm_div.sv
`default_nettype none
module bgtm_div #(
  parameter int DVW = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [bgtm_pkg::POS_W-1:0]   dividend,
  input  wire logic [DVW-1:0]               divisor,
  output logic                              done,
  output logic      [bgtm_pkg::POS_W-1:0]   quotient,
  output logic      [DVW-1:0]               remainder
);

  localparam int CW = $clog2(bgtm_pkg::DIV_STEPS);

  logic                        run_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [bgtm_pkg::POS_W-1:0]  quo_r;
  logic [DVW-1:0]              rem_r;
  logic [DVW-1:0]              dvs_r;
  logic [DVW:0]                trial;
  logic [DVW:0]                diff;
  logic                        ge;
  logic [DVW-1:0]              rem_nxt;

  // restoring division, one quotient bit per cycle; dividend bits shift out of quo_r
  always_comb begin
    trial   = {rem_r, quo_r[bgtm_pkg::POS_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVW-1:0] : trial[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(bgtm_pkg::DIV_STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[bgtm_pkg::POS_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

>>> rtl/bgtm_front.sv
`default_nettype none
module bgtm_front #(
  parameter int TILE_COUNT    = 512,
  parameter int PALETTE_COUNT = 8,
  parameter int MAP_ENTRIES   = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [9:0]           in_map_position,
  input  wire logic [7:0]           in_tile_number,
  input  wire logic                 in_page_select,
  input  wire logic                 in_mirror_horizontal,
  input  wire logic                 in_mirror_vertical,
  input  wire logic [2:0]           in_palette_choice,
  input  wire logic [14:0]          in_store_address,
  input  wire logic [31:0]          in_store_value,
  input  wire logic [bgtm_pkg::WIDTH_W-1:0] cfg_width,
  input  wire logic                 q_full,
  output logic                      q_push,
  output bgtm_pkg::bgtm_item_t      q_item
);

  localparam int DVW       = bgtm_pkg::WIDTH_W;
  localparam int PIX_DEPTH = TILE_COUNT * 64;
  localparam int PAL_DEPTH = PALETTE_COUNT * 16;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ROW  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                      state_r;
  bgtm_pkg::bgtm_item_t            item_r;
  logic [10:0]                     tile_raw;
  logic [bgtm_pkg::TILE_FW-1:0]    tile_wrap;
  logic [bgtm_pkg::PAL_FW-1:0]     pal_wrap;
  logic [bgtm_pkg::POS_W-1:0]      pos_wrap;
  logic [bgtm_pkg::WIDTH_W-1:0]    row_w;
  logic                            pix_ok;
  logic                            pal_ok;
  logic                            div_go;
  logic                            div_done;
  logic [bgtm_pkg::POS_W-1:0]      div_quo;
  logic [DVW-1:0]                  div_rem;

  // tile + page stays below twice the tile count, one subtract wraps it
  always_comb begin
    tile_raw = {2'b00, in_page_select, in_tile_number};
    if (tile_raw >= 11'(TILE_COUNT)) begin
      tile_wrap = bgtm_pkg::TILE_FW'(tile_raw - 11'(TILE_COUNT));
    end else begin
      tile_wrap = bgtm_pkg::TILE_FW'(tile_raw);
    end
  end

  always_comb begin
    unique case (in_palette_choice)
      3'd0:    pal_wrap = bgtm_pkg::PAL_FW'(0 % PALETTE_COUNT);
      3'd1:    pal_wrap = bgtm_pkg::PAL_FW'(1 % PALETTE_COUNT);
      3'd2:    pal_wrap = bgtm_pkg::PAL_FW'(2 % PALETTE_COUNT);
      3'd3:    pal_wrap = bgtm_pkg::PAL_FW'(3 % PALETTE_COUNT);
      3'd4:    pal_wrap = bgtm_pkg::PAL_FW'(4 % PALETTE_COUNT);
      3'd5:    pal_wrap = bgtm_pkg::PAL_FW'(5 % PALETTE_COUNT);
      3'd6:    pal_wrap = bgtm_pkg::PAL_FW'(6 % PALETTE_COUNT);
      default: pal_wrap = bgtm_pkg::PAL_FW'(7 % PALETTE_COUNT);
    endcase
  end

  // map position wraps by compare and subtract of shifted entry counts; the entry
  // count is at least 64, so four steps cover any 10-bit position
  always_comb begin
    pos_wrap = in_map_position;
    for (int j = 3; j >= 0; j--) begin
      if ((MAP_ENTRIES << j) < (1 << bgtm_pkg::POS_W) &&
          int'(pos_wrap) >= (MAP_ENTRIES << j)) begin
        pos_wrap = bgtm_pkg::POS_W'(int'(pos_wrap) - (MAP_ENTRIES << j));
      end
    end
  end

  always_comb begin
    if (cfg_width == '0) begin
      row_w = bgtm_pkg::WIDTH_W'(1);
    end else if (cfg_width > bgtm_pkg::WIDTH_W'(bgtm_pkg::MAX_ROW_W)) begin
      row_w = bgtm_pkg::WIDTH_W'(bgtm_pkg::MAX_ROW_W);
    end else begin
      row_w = cfg_width;
    end
  end

  assign pix_ok = {2'b00, in_store_address} < 17'(PIX_DEPTH);
  assign pal_ok = {2'b00, in_store_address} < 17'(PAL_DEPTH);

  // splits the wrapped map position into tile row and column
  assign div_go = state_r == F_IDLE && start && in_opcode == bgtm_pkg::OP_DRAW;

  bgtm_div #(.DVW(DVW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (pos_wrap),
    .divisor   (row_w),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            unique case (in_opcode)
              bgtm_pkg::OP_DRAW: state_r <= F_ROW;
              bgtm_pkg::OP_PIX:  state_r <= pix_ok ? F_PUSH : F_IDLE;
              bgtm_pkg::OP_PAL:  state_r <= pal_ok ? F_PUSH : F_IDLE;
              default:           state_r <= F_IDLE;
            endcase
          end
        end
        F_ROW: begin
          if (div_done) begin
            state_r <= F_PUSH;
          end
        end
        default: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      item_r.kind  <= in_opcode;
      item_r.tile  <= tile_wrap;
      item_r.hflip <= in_mirror_horizontal;
      item_r.vflip <= in_mirror_vertical;
      item_r.pal   <= pal_wrap;
      item_r.addr  <= in_store_address;
      item_r.value <= in_store_value;
    end
    if (state_r == F_ROW && div_done) begin
      item_r.col <= bgtm_pkg::COL_W'(div_rem);
      item_r.row <= div_quo;
    end
  end

  assign busy   = state_r != F_IDLE;
  assign q_push = state_r == F_PUSH && !q_full;
  assign q_item = item_r;

endmodule
`default_nettype wire

>>> rtl/bgtm_queue.sv
`default_nettype none
module bgtm_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire bgtm_pkg::bgtm_item_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output bgtm_pkg::bgtm_item_t      head_item,
  output logic                      empty
);

  localparam int PW = $clog2(bgtm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bgtm_pkg::QUEUE_DEPTH + 1);

  bgtm_pkg::bgtm_item_t slot_r [bgtm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [CW-1:0]        cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = cnt_r == CW'(bgtm_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item = slot_r[rd_ptr_r];

endmodule
`default_nettype wire

>>> rtl/bgtm_back.sv
`default_nettype none
module bgtm_back #(
  parameter int TILE_COUNT    = 512,
  parameter int PALETTE_COUNT = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_empty,
  input  wire bgtm_pkg::bgtm_item_t      q_item,
  output logic                           q_pop,
  input  wire logic [bgtm_pkg::VAL_W-1:0] bg_color,
  output logic                           out_valid,
  output logic      [bgtm_pkg::X_W-1:0]  out_pixel_x,
  output logic      [bgtm_pkg::Y_W-1:0]  out_pixel_y,
  output logic      [bgtm_pkg::VAL_W-1:0] out_pixel_color,
  output logic                           out_last_pixel
);

  localparam int PIX_DEPTH = TILE_COUNT * 64;
  localparam int PAL_DEPTH = PALETTE_COUNT * 16;
  localparam int PAW       = $clog2(PIX_DEPTH);
  localparam int PLAW      = $clog2(PAL_DEPTH);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_DRAW = 1'b1;

  logic                           state_r;
  bgtm_pkg::bgtm_item_t           cur_r;
  logic [5:0]                     k_r;
  logic [2:0]                     sx;
  logic [2:0]                     sy;
  logic                           issue;

  logic                           pix_we;
  logic [PAW-1:0]                 pix_rd_addr;
  logic [bgtm_pkg::IDX_W-1:0]     pix_rd_data;
  logic                           pal_we;
  logic [PLAW-1:0]                pal_rd_addr;
  logic [bgtm_pkg::VAL_W-1:0]     pal_rd_data;
  logic [3:0]                     idx_w;

  logic                           s1_v_r;
  logic [bgtm_pkg::X_W-1:0]       s1_x_r;
  logic [bgtm_pkg::Y_W-1:0]       s1_y_r;
  logic                           s1_last_r;
  logic [bgtm_pkg::PAL_FW-1:0]    s1_pal_r;

  logic                           s2_v_r;
  logic [bgtm_pkg::X_W-1:0]       s2_x_r;
  logic [bgtm_pkg::Y_W-1:0]       s2_y_r;
  logic                           s2_last_r;
  logic                           s2_bg_r;

  logic                           out_v_r;
  logic [bgtm_pkg::X_W-1:0]       out_x_r;
  logic [bgtm_pkg::Y_W-1:0]       out_y_r;
  logic [bgtm_pkg::VAL_W-1:0]     out_c_r;
  logic                           out_last_r;

  assign q_pop  = state_r == B_IDLE && !q_empty;
  assign issue  = state_r == B_DRAW;
  assign pix_we = q_pop && q_item.kind == bgtm_pkg::OP_PIX;
  assign pal_we = q_pop && q_item.kind == bgtm_pkg::OP_PAL;

  // a flip is 7 - n, which is n xor 7
  assign sx = k_r[2:0] ^ {3{cur_r.hflip}};
  assign sy = k_r[5:3] ^ {3{cur_r.vflip}};
  assign pix_rd_addr = PAW'({cur_r.tile, sy, sx});

  // indexes of 16 and up read as index 0
  assign idx_w = (pix_rd_data[bgtm_pkg::IDX_W-1:4] != '0) ? 4'd0 : pix_rd_data[3:0];
  assign pal_rd_addr = PLAW'({s1_pal_r, idx_w});

  bgtm_ram #(.WIDTH(bgtm_pkg::IDX_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
    .clk     (clk),
    .wr_en   (pix_we),
    .wr_addr (PAW'(q_item.addr)),
    .wr_data (q_item.value[bgtm_pkg::IDX_W-1:0]),
    .rd_en   (issue),
    .rd_addr (pix_rd_addr),
    .rd_data (pix_rd_data)
  );

  bgtm_ram #(.WIDTH(bgtm_pkg::VAL_W), .DEPTH(PAL_DEPTH)) u_pal_ram (
    .clk     (clk),
    .wr_en   (pal_we),
    .wr_addr (PLAW'(q_item.addr)),
    .wr_data (q_item.value),
    .rd_en   (s1_v_r),
    .rd_addr (pal_rd_addr),
    .rd_data (pal_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      k_r     <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (q_pop && q_item.kind == bgtm_pkg::OP_DRAW) begin
            state_r <= B_DRAW;
            k_r     <= '0;
          end
        end
        default: begin
          k_r <= k_r + 1'b1;
          if (&k_r) begin
            state_r <= B_IDLE;
          end
        end
      endcase
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    s1_x_r    <= {cur_r.col, k_r[2:0]};
    s1_y_r    <= {cur_r.row, k_r[5:3]};
    s1_last_r <= &k_r;
    s1_pal_r  <= cur_r.pal;
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s2_last_r <= s1_last_r;
    s2_bg_r   <= idx_w == 4'd0 && bg_color[bgtm_pkg::VAL_W-1:bgtm_pkg::ALPHA_LSB] != '0;
    out_x_r    <= s2_x_r;
    out_y_r    <= s2_y_r;
    out_last_r <= s2_last_r;
    out_c_r    <= s2_bg_r ? bg_color : pal_rd_data;
  end

  assign out_valid       = out_v_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_c_r;
  assign out_last_pixel  = out_v_r && out_last_r;

endmodule
`default_nettype wire

>>> rtl/bg_tile_map_renderer.sv
// Background tile renderer. Load items (opcode 1, 2) fill the tile pixel store and the
// palette store; a draw item (opcode 0) emits the 64 pixels of one 8x8 tile, row by row,
// on consecutive cycles, each marked by out_valid for one cycle, the last with
// out_last_pixel. The receiver cannot stall the output. Items pass in order through a
// four-entry queue. At the input, a load item keeps busy high until it is pushed and a
// draw item also while a 10-step division places the tile in the frame; the push waits
// while the queue is full. Unknown opcodes and loads beyond a store's depth are dropped
// at once. The pixel side pops an item only when idle and makes one pixel-store read per
// cycle for a draw, so it takes no new item until that draw's reads are all issued. From
// the queue head, a draw's first pixel passes the state register, the pixel-store read,
// the palette read and the output register. Stores hold nothing defined until loaded.
`default_nettype none
module bg_tile_map_renderer #(
  parameter int TILE_COUNT    = 512,
  parameter int PALETTE_COUNT = 8,
  parameter int MAP_ENTRIES   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [9:0]  in_map_position,
  input  wire logic [7:0]  in_tile_number,
  input  wire logic        in_page_select,
  input  wire logic        in_mirror_horizontal,
  input  wire logic        in_mirror_vertical,
  input  wire logic [2:0]  in_palette_choice,
  input  wire logic [14:0] in_store_address,
  input  wire logic [31:0] in_store_value,
  output logic             out_valid,
  output logic [8:0]       out_pixel_x,
  output logic [12:0]      out_pixel_y,
  output logic [31:0]      out_pixel_color,
  output logic             out_last_pixel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_BG    = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  logic [bgtm_pkg::VAL_W-1:0]   bg_r;
  logic [bgtm_pkg::WIDTH_W-1:0] width_r;
  logic                         cfg_we;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_empty;
  bgtm_pkg::bgtm_item_t         q_in;
  bgtm_pkg::bgtm_item_t         q_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r    <= '0;
      width_r <= bgtm_pkg::WIDTH_W'(32);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_BG:  bg_r    <= pwdata;
        default: width_r <= pwdata[bgtm_pkg::WIDTH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH: prdata = {{(32 - bgtm_pkg::WIDTH_W){1'b0}}, width_r};
      default:   prdata = bg_r;
    endcase
  end

  bgtm_front #(
    .TILE_COUNT    (TILE_COUNT),
    .PALETTE_COUNT (PALETTE_COUNT),
    .MAP_ENTRIES   (MAP_ENTRIES)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_map_position      (in_map_position),
    .in_tile_number       (in_tile_number),
    .in_page_select       (in_page_select),
    .in_mirror_horizontal (in_mirror_horizontal),
    .in_mirror_vertical   (in_mirror_vertical),
    .in_palette_choice    (in_palette_choice),
    .in_store_address     (in_store_address),
    .in_store_value       (in_store_value),
    .cfg_width            (width_r),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_item               (q_in)
  );

  bgtm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head),
    .empty     (q_empty)
  );

  bgtm_back #(
    .TILE_COUNT    (TILE_COUNT),
    .PALETTE_COUNT (PALETTE_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .bg_color        (bg_r),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
`default_nettype wire

>>> rtl/bgtm_checker.sv
`default_nettype none
module bgtm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic [8:0]  out_pixel_x,
  input wire logic [12:0] out_pixel_y,
  input wire logic        out_last_pixel
);

  // no pixel leaves right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel strobe right after reset");

  // a draw holds the input side for its placement
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == bgtm_pkg::OP_DRAW |=> busy)
    else $error("draw item did not raise busy");

  // the 64 pixels of a tile come out back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_valid)
    else $error("gap inside a tile burst");

  // last pixel sits at the bottom right corner of its tile
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_pixel_x[2:0] == 3'd7 && out_pixel_y[2:0] == 3'd7)
    else $error("last pixel not at tile corner");

  // within a tile row, columns step by one
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_x[2:0] != 3'd7 |=> out_pixel_x == $past(out_pixel_x) + 9'd1)
    else $error("pixel column out of order");

endmodule

bind bg_tile_map_renderer bgtm_checker u_bgtm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_last_pixel (out_last_pixel)
);
`default_nettype wire

>>> tb/bg_tile_map_renderer_test.sv
`default_nettype none
module bg_tile_map_renderer_test;

  localparam int TILE_COUNT    = 512;
  localparam int PALETTE_COUNT = 8;
  localparam int MAP_ENTRIES   = 1024;
  localparam int TILE_DIM      = 8;
  localparam int TILE_PIXELS   = 64;
  localparam int PAL_SIZE      = 16;
  localparam int PIX_DEPTH     = TILE_COUNT * TILE_PIXELS;
  localparam int PAL_DEPTH     = PALETTE_COUNT * PAL_SIZE;
  localparam int ADDR_MAX      = 32767;
  localparam int POS_MAX       = 1023;
  localparam int DRAW_PAL      = 5;

  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam logic [2:0] REG_BG_COLOR = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd4;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int QUIET_CYCLES = 16;
  localparam int TAIL_CYCLES  = 80;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASES       = 4;
  localparam int PHASE_ACTS   = 5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  map_pos;
    logic [7:0]  tile_num;
    logic        page;
    logic        hmir;
    logic        vmir;
    logic [2:0]  pal;
    logic [14:0] addr;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  x;
    logic [12:0] y;
    logic [31:0] color;
    logic        last;
  } pixel_t;

  // Tracks the stores and registers, expands each draw into its 64 pixels
  class pixel_scoreboard;
    logic [7:0]  tile_pix [PIX_DEPTH];
    logic [31:0] colors [PAL_DEPTH];
    logic [31:0] bg_color;
    logic [6:0]  width_tiles;
    pixel_t      pending [$];
    int          errors;

    function new();
      bg_color    = '0;
      width_tiles = 7'd32;
      errors      = 0;
    endfunction

    function void write_reg(logic [2:0] a, logic [31:0] d);
      if (a == REG_BG_COLOR) begin
        bg_color = d;
      end else if (a == REG_WIDTH) begin
        width_tiles = d[6:0];
      end
    endfunction

    function void expand_tile(cmd_t c);
      int w, tile, pal, pos, bx, by, sx, sy;
      logic [7:0] idx;
      pixel_t p;
      w = (width_tiles == 0) ? 1 :
          (width_tiles > bgtm_pkg::MAX_ROW_W) ? bgtm_pkg::MAX_ROW_W : int'(width_tiles);
      tile = {c.page, c.tile_num} % TILE_COUNT;
      pal  = c.pal % PALETTE_COUNT;
      pos  = c.map_pos % MAP_ENTRIES;
      bx   = (pos % w) * TILE_DIM;
      by   = (pos / w) * TILE_DIM;
      for (int row = 0; row < TILE_DIM; row++) begin
        for (int col = 0; col < TILE_DIM; col++) begin
          sx  = c.hmir ? TILE_DIM - 1 - col : col;
          sy  = c.vmir ? TILE_DIM - 1 - row : row;
          idx = tile_pix[tile * TILE_PIXELS + sy * TILE_DIM + sx];
          if (idx >= PAL_SIZE) idx = '0;  // out-of-range index reads as transparent
          p.x     = 9'(bx + col);
          p.y     = 13'(by + row);
          p.color = (idx == 0 && bg_color[31:bgtm_pkg::ALPHA_LSB] != 0) ? bg_color :
                    colors[pal * PAL_SIZE + int'(idx)];
          p.last  = (row == TILE_DIM - 1) && (col == TILE_DIM - 1);
          pending = {pending, p};
        end
      end
    endfunction

    function void note_item(cmd_t c);
      case (c.opcode)
        bgtm_pkg::OP_PIX: begin
          if (c.addr < PIX_DEPTH) tile_pix[c.addr] = c.value[7:0];
        end
        bgtm_pkg::OP_PAL: begin
          if (c.addr < PAL_DEPTH) colors[c.addr] = c.value;
        end
        bgtm_pkg::OP_DRAW: begin
          expand_tile(c);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected pixel: x=%0d y=%0d color=%h last=%0b",
                   got.x, got.y, got.color, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"pixel mismatch: expected x=%0d y=%0d color=%h last=%0b, ",
                    "got x=%0d y=%0d color=%h last=%0b"},
                   want.x, want.y, want.color, want.last,
                   got.x, got.y, got.color, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [9:0]  in_map_position;
  logic [7:0]  in_tile_number;
  logic        in_page_select;
  logic        in_mirror_horizontal;
  logic        in_mirror_vertical;
  logic [2:0]  in_palette_choice;
  logic [14:0] in_store_address;
  logic [31:0] in_store_value;
  logic        out_valid;
  logic [8:0]  out_pixel_x;
  logic [12:0] out_pixel_y;
  logic [31:0] out_pixel_color;
  logic        out_last_pixel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_scoreboard sb;
  bit              idle_on;
  bit              tile_ready [TILE_COUNT];
  bit              pal_ready [PALETTE_COUNT];
  int              ready_tiles [$];
  int              ready_pals [$];
  int              cycles = 0;

  bg_tile_map_renderer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_map_position      (in_map_position),
    .in_tile_number       (in_tile_number),
    .in_page_select       (in_page_select),
    .in_mirror_horizontal (in_mirror_horizontal),
    .in_mirror_vertical   (in_mirror_vertical),
    .in_palette_choice    (in_palette_choice),
    .in_store_address     (in_store_address),
    .in_store_value       (in_store_value),
    .out_valid            (out_valid),
    .out_pixel_x          (out_pixel_x),
    .out_pixel_y          (out_pixel_y),
    .out_pixel_color      (out_pixel_color),
    .out_last_pixel       (out_last_pixel),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_pixel({out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel});
  end

  function automatic cmd_t random_cmd(logic [1:0] op);
    cmd_t c;
    c.opcode   = op;
    c.map_pos  = 10'($urandom());
    c.tile_num = 8'($urandom());
    c.page     = 1'($urandom());
    c.hmir     = 1'($urandom());
    c.vmir     = 1'($urandom());
    c.pal      = 3'($urandom());
    c.addr     = 15'($urandom());
    c.value    = $urandom();
    return c;
  endfunction

  // mostly palette indexes, with transparent and out-of-range ones mixed in
  function automatic logic [7:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(1, 15));
    if (r == 7) return 8'd0;
    return 8'($urandom_range(16, 255));
  endfunction

  function automatic logic [6:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      default: return 7'($urandom_range(2, 63));
    endcase
  endfunction

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
    @(negedge clk);
    start                <= 1'b1;
    in_opcode            <= c.opcode;
    in_map_position      <= c.map_pos;
    in_tile_number       <= c.tile_num;
    in_page_select       <= c.page;
    in_mirror_horizontal <= c.hmir;
    in_mirror_vertical   <= c.vmir;
    in_palette_choice    <= c.pal;
    in_store_address     <= c.addr;
    in_store_value       <= c.value;
    do @(posedge clk); while (busy);
    sb.note_item(c);
  endtask

  // stop sending and let every pending pixel and queued load go through
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(a, d);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] bg, logic [6:0] w);
    drain();
    reg_write(REG_BG_COLOR, bg);
    reg_write(REG_WIDTH, {25'd0, w});
  endtask

  task automatic load_pixel(int a, logic [7:0] idx);
    cmd_t c;
    c = random_cmd(bgtm_pkg::OP_PIX);
    c.addr = 15'(a);
    c.value[7:0] = idx;
    send(c);
  endtask

  task automatic load_color(int a, logic [31:0] v);
    cmd_t c;
    c = random_cmd(bgtm_pkg::OP_PAL);
    c.addr  = 15'(a);
    c.value = v;
    send(c);
  endtask

  task automatic draw(int pos, int tile, bit h, bit v, int pal);
    cmd_t c;
    c = random_cmd(bgtm_pkg::OP_DRAW);
    c.map_pos = 10'(pos);
    {c.page, c.tile_num} = 9'(tile);
    c.hmir = h;
    c.vmir = v;
    c.pal  = 3'(pal);
    send(c);
  endtask

  task automatic fill_tile(int t);
    for (int i = 0; i < TILE_PIXELS; i++) load_pixel(t * TILE_PIXELS + i, pick_index());
    if (!tile_ready[t]) begin
      tile_ready[t] = 1'b1;
      ready_tiles = {ready_tiles, t};
    end
  endtask

  task automatic fill_palette(int p);
    for (int i = 0; i < PAL_SIZE; i++) load_color(p * PAL_SIZE + i, $urandom());
    if (!pal_ready[p]) begin
      pal_ready[p] = 1'b1;
      ready_pals = {ready_pals, p};
    end
  endtask

  // draws only touch tiles and palettes that are fully loaded
  task automatic draw_random();
    draw($urandom_range(0, POS_MAX),
         ready_tiles[$urandom_range(0, ready_tiles.size() - 1)],
         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
         ready_pals[$urandom_range(0, ready_pals.size() - 1)]);
  endtask

  task automatic random_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      draw_random();
    end else if (r < 72) begin
      load_pixel(ready_tiles[$urandom_range(0, ready_tiles.size() - 1)] * TILE_PIXELS +
                 $urandom_range(0, TILE_PIXELS - 1), pick_index());
    end else if (r < 80) begin
      load_color($urandom_range(0, PAL_DEPTH - 1), $urandom());
    end else if (r < 86) begin
      send(random_cmd(OP_NONE));
    end else if (r < 92) begin
      load_color($urandom_range(PAL_DEPTH, ADDR_MAX), $urandom());
    end else if (r < 97) begin
      load_pixel($urandom_range(0, PIX_DEPTH - 1), pick_index());
    end else begin
      drain();
    end
  endtask

  initial begin
    logic [31:0] bg;
    sb                   = new();
    rst_n                = 1'b0;
    start                = 1'b0;
    in_opcode            = bgtm_pkg::OP_DRAW;
    in_map_position      = '0;
    in_tile_number       = '0;
    in_page_select       = 1'b0;
    in_mirror_horizontal = 1'b0;
    in_mirror_vertical   = 1'b0;
    in_palette_choice    = '0;
    in_store_address     = '0;
    in_store_value       = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    idle_on              = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    set_config(32'd0, 7'd32);
    fill_palette(DRAW_PAL);
    fill_tile(0);
    fill_tile(TILE_COUNT - 1);

    // transparent, out-of-range and largest indexes at known spots of tile 0
    load_pixel(0, 8'd0);
    load_pixel(1, 8'd16);
    load_pixel(2, 8'd15);
    load_pixel(TILE_PIXELS - 1, 8'd255);
    load_color(DRAW_PAL * PAL_SIZE, 32'hFFFF_FFFF);
    load_color(PAL_DEPTH - 1, 32'h0000_0000);
    send(random_cmd(OP_NONE));
    load_color(PAL_DEPTH, 32'hDEAD_BEEF);
    load_color(ADDR_MAX, 32'h1234_5678);
    draw(0, 0, 1'b0, 1'b0, DRAW_PAL);
    draw(POS_MAX, TILE_COUNT - 1, 1'b1, 1'b0, DRAW_PAL);
    draw(5, 0, 1'b0, 1'b1, DRAW_PAL);
    draw(33, TILE_COUNT - 1, 1'b1, 1'b1, DRAW_PAL);

    set_config(32'h0123_4567, 7'd1);
    draw(POS_MAX, 0, 1'b0, 1'b0, DRAW_PAL);
    set_config(32'hFFFF_FFFF, 7'd64);
    draw(POS_MAX, TILE_COUNT - 1, 1'b1, 1'b1, DRAW_PAL);
    set_config(32'h00FF_FFFF, 7'd0);
    draw(POS_MAX, 0, 1'b1, 1'b0, DRAW_PAL);
    draw(0, TILE_COUNT - 1, 1'b0, 1'b1, DRAW_PAL);
    set_config(32'h8000_0000, 7'd127);
    draw(POS_MAX, 0, 1'b0, 1'b0, DRAW_PAL);
    set_config(32'd0, 7'd65);
    draw(700, TILE_COUNT - 1, 1'b0, 1'b0, DRAW_PAL);

    for (int phase = 0; phase < PHASES; phase++) begin
      bg = $urandom();
      if ($urandom_range(0, 1) == 0) bg[31:bgtm_pkg::ALPHA_LSB] = '0;
      set_config(bg, pick_width());
      // no idling in the closing stretch of the run
      idle_on = phase < PHASES - 1 && $urandom_range(0, 2) != 0;
      for (int n = 0; n < PHASE_ACTS; n++) begin
        random_action();
      end
    end

    idle_on = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
